/* rtl/stable_priority_queue_defines.svh */
// ----------------------------------------------------------------------------
// stable priority queue assertion macros
// Shared concurrent check macros, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk and quiet in reset
`define SPQ_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spq: same-cycle check failed");

// next-cycle implication, sampled on clk and quiet in reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spq: next-cycle check failed");

`else

`define SPQ_ASSERT_IMPLY(lbl, ante, cons)
`define SPQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* rtl/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types, codes and defaults shared by the priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

  // default sizes
  localparam int DEPTH_DEF      = 16;
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int PRIO_WIDTH_DEF = 8;

  // port field widths
  localparam int ACTION_W      = 2;
  localparam int ELEM_W        = 32;
  localparam int PRIO_W        = 8;
  localparam int COUNT_W       = 5;
  localparam int STATUS_W      = 2;
  localparam int IN_TDATA_W    = 40;
  localparam int IN_TUSER_W    = 2;
  localparam int OUT_TDATA_W   = 48;
  localparam int OUT_TUSER_W   = 3;
  localparam int OUT_TDATA_PAD = OUT_TDATA_W - ELEM_W - PRIO_W - COUNT_W;

  // word actions
  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_QRY = 2'd2,
    ACT_CLR = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // what every cell does: hold, insert or shift
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  // control handed to each cell
  typedef struct packed {
    cell_op_t op;
    logic     occupied;
  } cell_ctl_t;

endpackage

/* rtl/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: compares against the incoming priority and
// keeps, takes the new pair, or takes its neighbour's pair.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH_DEF,
  parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                  clk,
  input  spq_pkg::cell_ctl_t    ctl,
  input  logic [ELEM_WIDTH-1:0] new_value,
  input  logic [PRIO_WIDTH-1:0] new_rank,
  input  logic                  prev_behind,
  input  logic [ELEM_WIDTH-1:0] prev_value,
  input  logic [PRIO_WIDTH-1:0] prev_rank,
  input  logic [ELEM_WIDTH-1:0] next_value,
  input  logic [PRIO_WIDTH-1:0] next_rank,
  output logic [ELEM_WIDTH-1:0] value,
  output logic [PRIO_WIDTH-1:0] rank,
  output logic [ELEM_WIDTH-1:0] value_next,
  output logic [PRIO_WIDTH-1:0] rank_next,
  output logic                  behind
);

  // new pair goes behind this entry if occupied and equal or more urgent
  assign behind = ctl.occupied && (rank <= new_rank);

  // slot contents for the next cycle
  always_comb begin
    value_next = value;
    rank_next  = rank;
    case (ctl.op)
      spq_pkg::CELL_HOLD: begin
        value_next = value;
        rank_next  = rank;
      end
      spq_pkg::CELL_INSERT: begin
        if (behind) begin
          value_next = value;
          rank_next  = rank;
        end else if (prev_behind) begin
          value_next = new_value;
          rank_next  = new_rank;
        end else begin
          value_next = prev_value;
          rank_next  = prev_rank;
        end
      end
      spq_pkg::CELL_SHIFT: begin
        value_next = next_value;
        rank_next  = next_rank;
      end
      default: begin
        value_next = value;
        rank_next  = rank;
      end
    endcase
  end

  // slot storage, meaningful only while occupied
  always_ff @(posedge clk) begin
    value <= value_next;
    rank  <= rank_next;
  end

endmodule

/* rtl/stable_priority_queue.sv */
`timescale 1ns / 1ps
// a result word is registered and appears in the cycle after its input word is taken
// throughput: one word per cycle while the result side keeps taking words
// the figure is set by the row of cells, which all compare and shift in the same cycle
// reset clears the entry count and the result valid; slot contents stay as
// they are and are never read before being written
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded stable priority queue kept sorted in a row of compare/shift cells.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int DEPTH      = spq_pkg::DEPTH_DEF,
  parameter int ELEM_WIDTH = spq_pkg::ELEM_WIDTH_DEF,
  parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // elem [31:0], priority_req [39:32]
  input  logic [spq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  logic [spq_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // front_elem [31:0], front_priority [39:32], count [44:40], zero [47:45]
  output logic [spq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // front_valid [0], status [2:1]
  output logic [spq_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

  localparam int CW = $clog2(DEPTH + 1);

  logic                      s_accept;
  spq_pkg::action_t          act;
  logic [63:0]               elem_wide;
  logic [31:0]               prio_wide;
  logic [ELEM_WIDTH-1:0]     new_value;
  logic [PRIO_WIDTH-1:0]     new_rank;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic                      full;
  logic                      empty;
  spq_pkg::cell_op_t         op;
  spq_pkg::status_t          status_next;
  spq_pkg::cell_ctl_t        cell_ctl    [DEPTH];
  logic [ELEM_WIDTH-1:0]     cell_value  [DEPTH];
  logic [PRIO_WIDTH-1:0]     cell_rank   [DEPTH];
  logic [ELEM_WIDTH-1:0]     cell_value_next [DEPTH];
  logic [PRIO_WIDTH-1:0]     cell_rank_next  [DEPTH];
  logic [DEPTH-1:0]          cell_behind;
  logic                      out_valid;
  logic [ELEM_WIDTH-1:0]     front_value;
  logic [PRIO_WIDTH-1:0]     front_rank;
  logic                      front_valid;
  logic [CW-1:0]             count_out;
  spq_pkg::status_t          status;
  logic [63:0]               front_value_wide;
  logic [31:0]               front_rank_wide;
  logic [31:0]               count_wide;

  // handshake: the result register frees as its word is taken
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // input word unpacking
  assign act       = spq_pkg::action_t'(s_axis_tuser);
  assign elem_wide = 64'(s_axis_tdata[31:0]);
  assign prio_wide = 32'(s_axis_tdata[39:32]);
  assign new_value = elem_wide[ELEM_WIDTH-1:0];
  assign new_rank  = prio_wide[PRIO_WIDTH-1:0];

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // action decode
  always_comb begin
    op          = spq_pkg::CELL_HOLD;
    count_next  = count;
    status_next = spq_pkg::ST_DONE;
    if (s_accept) begin
      case (act)
        spq_pkg::ACT_ENQ: begin
          if (full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            op         = spq_pkg::CELL_INSERT;
            count_next = count + CW'(1);
          end
        end
        spq_pkg::ACT_DEQ: begin
          if (empty) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            op         = spq_pkg::CELL_SHIFT;
            count_next = count - CW'(1);
          end
        end
        spq_pkg::ACT_QRY: begin
          count_next = count;
        end
        spq_pkg::ACT_CLR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  // row of cells linked to neighbours; the head's previous pair is the input
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_behind;
    logic [ELEM_WIDTH-1:0] prev_value;
    logic [PRIO_WIDTH-1:0] prev_rank;
    logic [ELEM_WIDTH-1:0] next_value;
    logic [PRIO_WIDTH-1:0] next_rank;

    assign cell_ctl[i].op       = op;
    assign cell_ctl[i].occupied = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign prev_behind = 1'b1;
      assign prev_value  = new_value;
      assign prev_rank   = new_rank;
    end else begin : g_body
      assign prev_behind = cell_behind[i-1];
      assign prev_value  = cell_value[i-1];
      assign prev_rank   = cell_rank[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = cell_value[i];
      assign next_rank  = cell_rank[i];
    end else begin : g_link
      assign next_value = cell_value[i+1];
      assign next_rank  = cell_rank[i+1];
    end

    spq_cell #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl[i]),
      .new_value   (new_value),
      .new_rank    (new_rank),
      .prev_behind (prev_behind),
      .prev_value  (prev_value),
      .prev_rank   (prev_rank),
      .next_value  (next_value),
      .next_rank   (next_rank),
      .value       (cell_value[i]),
      .rank        (cell_rank[i]),
      .value_next  (cell_value_next[i]),
      .rank_next   (cell_rank_next[i]),
      .behind      (cell_behind[i])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      front_valid <= (count_next != '0);
      front_value <= (count_next != '0) ? cell_value_next[0] : '0;
      front_rank  <= (count_next != '0) ? cell_rank_next[0] : '0;
      count_out   <= count_next;
      status      <= status_next;
    end
  end

  // result word packing
  assign front_value_wide = 64'(front_value);
  assign front_rank_wide  = 32'(front_rank);
  assign count_wide       = 32'(count_out);

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{spq_pkg::OUT_TDATA_PAD{1'b0}},
                          count_wide[spq_pkg::COUNT_W-1:0],
                          front_rank_wide[spq_pkg::PRIO_W-1:0],
                          front_value_wide[spq_pkg::ELEM_W-1:0]};
  assign m_axis_tuser  = {status, front_valid};

  // checks
  `SPQ_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CW'(DEPTH))
  `SPQ_ASSERT_IMPLY(a_head_sorted, CW'(1) < count, cell_rank[0] <= cell_rank[1])
  `SPQ_ASSERT_NEXT(a_full_reject, s_accept && (act == spq_pkg::ACT_ENQ) && full, $stable(count))
  `SPQ_ASSERT_NEXT(a_clear_empties, s_accept && (act == spq_pkg::ACT_CLR), count == '0)
  `SPQ_ASSERT_IMPLY(a_front_flag, out_valid, front_valid == (count_out != '0))

endmodule
